@@ rtl/akf_pkg.sv @@
// ----------------------------------------------------------------------------
// akf_pkg: shared types and helpers for the angle/bias kalman filter
// fixed-point saturation helpers and the word formats of both channels
// ----------------------------------------------------------------------------
package akf_pkg;

  localparam int MUL_DIG   = 4;
  localparam int MUL_STEPS = 64 / MUL_DIG;
  localparam int DIV_STEPS = 112;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  localparam logic [1:0] REG_ANGLE_NOISE   = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE    = 2'd1;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

  localparam logic [47:0] ANGLE_NOISE_RST   = 48'd2251799814;
  localparam logic [47:0] BIAS_NOISE_RST    = 48'd84442;
  localparam logic [47:0] MEASURE_NOISE_RST = 48'd8444249301320;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] measured_angle;
    logic signed [31:0] gyro_rate;
    logic        [23:0] time_step;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] filtered_angle;
    logic signed [31:0] unbiased_rate;
  } out_word_t;

  typedef struct packed {
    logic               start;
    logic               q48;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] n;
    logic signed [63:0] d;
  } div_req_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? (64'd0 - 64'(v)) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sadd64 = s[64] ? S64_MIN : S64_MAX;
    else sadd64 = s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) ssub64 = s[64] ? S64_MIN : S64_MAX;
    else ssub64 = s[63:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if ((&v[63:31]) || !(|v[63:31])) clamp32 = v[31:0];
    else clamp32 = v[63] ? S32_MIN : S32_MAX;
  endfunction

endpackage

@@ rtl/angle_kalman_filter_2state_top.sv @@
// ----------------------------------------------------------------------------
// angle_kalman_filter_2state_top: angle and gyro bias kalman filter
// two-state predict/correct on a shared serial multiplier and divider
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall carry one input word (mode, measured angle, gyro rate,
//   time step); out_valid/out_stall return one word per input (filtered angle,
//   unbiased rate). a word moves when valid is high and stall is low.
//   mode 1 loads the angle: the word goes straight to the output state, and
//   no new word is taken until its result is loaded.
//   mode 0 runs ten products on the 4-bit-per-cycle multiplier and two gains
//   on the 1-bit-per-cycle divider (a zero divisor skips the division), one
//   after another; again no new word is taken until the result is loaded.
//   in_stall stays high the whole time a word is in work.
//   noise registers sit on an apb port at byte addresses 0, 8 and 16
//   (64-bit data, low 48 bits used); write them only while idle.
//   reset clears the estimates and covariance and loads the noise defaults.
//   the result waits in an output register; a new word is taken meanwhile,
//   but its result is held back until the receiver drops out_stall.
// ----------------------------------------------------------------------------
module angle_kalman_filter_2state_top
  import akf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_ANG, S_DTBB, S_AA, S_BB, S_K0, S_K1,
    S_CA, S_CB, S_PA, S_PB, S_PC, S_PD, S_OUT
  } state_t;

  state_t state_r;
  logic   run_r;

  logic [47:0] angle_noise_r, bias_noise_r, measure_noise_r;

  logic signed [31:0] angle_r, bias_r, last_rate_r, meas_r;
  logic        [23:0] dt_r;
  logic signed [63:0] aa_r, ab_r, ba_r, bb_r;
  logic signed [63:0] dtbb_r, t_r, s_r, k0_r, k1_r, y_r, aa0_r, ab0_r;

  logic        out_valid_r;
  out_word_t   out_data_r;

  mul_req_t mreq;
  div_req_t dreq;
  logic               mdone, ddone;
  logic signed [63:0] mres, dres;
  logic signed [63:0] dt64;
  logic               accept;
  logic               out_load;

  assign dt64   = {40'b0, dt_r};
  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // operand select for the shared units
  always_comb begin
    mreq = '0;
    dreq = '0;
    unique case (state_r)
      S_ANG:  begin mreq.a = dt64; mreq.b = 64'(last_rate_r); end
      S_DTBB: begin mreq.a = dt64; mreq.b = bb_r; end
      S_AA:   begin mreq.a = dt64; mreq.b = t_r; end
      S_BB:   begin mreq.a = {16'b0, bias_noise_r}; mreq.b = dt64; end
      S_CA:   begin mreq.a = k0_r; mreq.b = y_r; mreq.q48 = 1'b1; end
      S_CB:   begin mreq.a = k1_r; mreq.b = y_r; mreq.q48 = 1'b1; end
      S_PA:   begin mreq.a = k0_r; mreq.b = aa_r; mreq.q48 = 1'b1; end
      S_PB:   begin mreq.a = k0_r; mreq.b = ab_r; mreq.q48 = 1'b1; end
      S_PC:   begin mreq.a = k1_r; mreq.b = aa0_r; mreq.q48 = 1'b1; end
      S_PD:   begin mreq.a = k1_r; mreq.b = ab0_r; mreq.q48 = 1'b1; end
      S_K0:   begin dreq.n = aa_r; dreq.d = s_r; end
      S_K1:   begin dreq.n = ba_r; dreq.d = s_r; end
      default: ;
    endcase
    mreq.start = !run_r && (state_r == S_ANG || state_r == S_DTBB ||
                 state_r == S_AA || state_r == S_BB || state_r == S_CA ||
                 state_r == S_CB || state_r == S_PA || state_r == S_PB ||
                 state_r == S_PC || state_r == S_PD);
    dreq.start = !run_r && (state_r == S_K0 || state_r == S_K1);
  end

  akf_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .done(mdone), .res(mres));
  akf_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .res(dres));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      run_r           <= 1'b0;
      out_valid_r     <= 1'b0;
      angle_noise_r   <= ANGLE_NOISE_RST;
      bias_noise_r    <= BIAS_NOISE_RST;
      measure_noise_r <= MEASURE_NOISE_RST;
      angle_r         <= '0;
      bias_r          <= '0;
      last_rate_r     <= '0;
      aa_r            <= '0;
      ab_r            <= '0;
      ba_r            <= '0;
      bb_r            <= '0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) out_valid_r <= 1'b0;

      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        unique case (cfg_paddr[4:3])
          REG_ANGLE_NOISE:   angle_noise_r   <= cfg_pwdata[47:0];
          REG_BIAS_NOISE:    bias_noise_r    <= cfg_pwdata[47:0];
          REG_MEASURE_NOISE: measure_noise_r <= cfg_pwdata[47:0];
          default: ;
        endcase
      end

      if (mreq.start || dreq.start) run_r <= 1'b1;

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            meas_r <= in_data.measured_angle;
            dt_r   <= in_data.time_step;
            if (in_data.mode == MODE_LOAD) begin
              angle_r <= in_data.measured_angle;
              state_r <= S_OUT;
            end else begin
              last_rate_r <= clamp32(64'(in_data.gyro_rate) - 64'(bias_r));
              state_r     <= S_ANG;
            end
          end
        end
        S_ANG: if (mdone) begin
          angle_r <= clamp32(sadd64(64'(angle_r), mres));
          run_r   <= 1'b0;
          state_r <= S_DTBB;
        end
        S_DTBB: if (mdone) begin
          dtbb_r  <= mres;
          t_r     <= sadd64(ssub64(ssub64(mres, ab_r), ba_r), {16'b0, angle_noise_r});
          run_r   <= 1'b0;
          state_r <= S_AA;
        end
        S_AA: if (mdone) begin
          aa_r    <= sadd64(aa_r, mres);
          ab_r    <= ssub64(ab_r, dtbb_r);
          ba_r    <= ssub64(ba_r, dtbb_r);
          run_r   <= 1'b0;
          state_r <= S_BB;
        end
        S_BB: if (mdone) begin
          bb_r    <= sadd64(bb_r, mres);
          s_r     <= sadd64(aa_r, {16'b0, measure_noise_r});
          run_r   <= 1'b0;
          state_r <= S_K0;
        end
        S_K0: if (ddone) begin
          k0_r    <= dres;
          run_r   <= 1'b0;
          state_r <= S_K1;
        end
        S_K1: if (ddone) begin
          k1_r    <= dres;
          y_r     <= 64'(meas_r) - 64'(angle_r);
          run_r   <= 1'b0;
          state_r <= S_CA;
        end
        S_CA: if (mdone) begin
          angle_r <= clamp32(sadd64(64'(angle_r), mres));
          run_r   <= 1'b0;
          state_r <= S_CB;
        end
        S_CB: if (mdone) begin
          bias_r  <= clamp32(sadd64(64'(bias_r), mres));
          run_r   <= 1'b0;
          state_r <= S_PA;
        end
        // later products need the covariance from before the correction
        S_PA: if (mdone) begin
          aa0_r   <= aa_r;
          aa_r    <= ssub64(aa_r, mres);
          run_r   <= 1'b0;
          state_r <= S_PB;
        end
        S_PB: if (mdone) begin
          ab0_r   <= ab_r;
          ab_r    <= ssub64(ab_r, mres);
          run_r   <= 1'b0;
          state_r <= S_PC;
        end
        S_PC: if (mdone) begin
          ba_r    <= ssub64(ba_r, mres);
          run_r   <= 1'b0;
          state_r <= S_PD;
        end
        S_PD: if (mdone) begin
          bb_r    <= ssub64(bb_r, mres);
          run_r   <= 1'b0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r                  <= 1'b1;
            out_data_r.filtered_angle    <= angle_r;
            out_data_r.unbiased_rate     <= last_rate_r;
            state_r                      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:3])
      REG_ANGLE_NOISE:   cfg_prdata = {16'b0, angle_noise_r};
      REG_BIAS_NOISE:    cfg_prdata = {16'b0, bias_noise_r};
      REG_MEASURE_NOISE: cfg_prdata = {16'b0, measure_noise_r};
      default:           cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

endmodule

@@ rtl/akf_mul.sv @@
// ----------------------------------------------------------------------------
// akf_mul: digit-serial signed multiplier
// four multiplier bits per cycle, then floor shift by 24 or 48 and saturation
// ----------------------------------------------------------------------------
module akf_mul
  import akf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  mul_req_t           req,
  output logic               done,
  output logic signed [63:0] res
);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_NEG, M_SHF} mstate_t;

  mstate_t      state_r;
  logic [127:0] acc_r;
  logic [63:0]  ua_r;
  logic [63:0]  ub_r;
  logic         neg_r;
  logic         q48_r;
  logic [3:0]   cnt_r;
  logic         done_r;
  logic signed [63:0] res_r;

  logic [67:0] part;
  logic [67:0] sum;
  logic signed [127:0] sh;

  always_comb begin
    part = {4'b0, ua_r} * {64'b0, ub_r[MUL_DIG-1:0]};
    sum  = {4'b0, acc_r[127:64]} + part;
    sh   = q48_r ? ($signed(acc_r) >>> 48) : ($signed(acc_r) >>> 24);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (req.start) begin
            ua_r    <= mag64(req.a);
            ub_r    <= mag64(req.b);
            neg_r   <= req.a[63] ^ req.b[63];
            q48_r   <= req.q48;
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= M_RUN;
          end
        end
        M_RUN: begin
          acc_r <= {sum, acc_r[63:MUL_DIG]};
          ub_r  <= ub_r >> MUL_DIG;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'(MUL_STEPS - 1)) state_r <= M_NEG;
        end
        M_NEG: begin
          if (neg_r) acc_r <= 128'd0 - acc_r;
          state_r <= M_SHF;
        end
        M_SHF: begin
          if ((&sh[127:63]) || !(|sh[127:63])) res_r <= sh[63:0];
          else res_r <= sh[127] ? S64_MIN : S64_MAX;
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

@@ rtl/akf_div.sv @@
// ----------------------------------------------------------------------------
// akf_div: bit-serial restoring divider
// (n << 48) / d truncated toward zero, saturated, zero for a zero divisor
// ----------------------------------------------------------------------------
module akf_div
  import akf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  div_req_t           req,
  output logic               done,
  output logic signed [63:0] res
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t      state_r;
  logic [111:0] dvd_r;
  logic [63:0]  rem_r;
  logic [63:0]  ud_r;
  logic [63:0]  q_r;
  logic         ovf_r;
  logic         neg_r;
  logic [6:0]   cnt_r;
  logic         done_r;
  logic signed [63:0] res_r;

  logic [64:0] r2;
  logic        ge;

  always_comb begin
    r2 = {rem_r, dvd_r[111]};
    ge = r2 >= {1'b0, ud_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (req.start) begin
            if (req.d == 64'sd0) begin
              res_r  <= '0;
              done_r <= 1'b1;
            end else begin
              dvd_r   <= {mag64(req.n), 48'b0};
              ud_r    <= mag64(req.d);
              neg_r   <= req.n[63] ^ req.d[63];
              rem_r   <= '0;
              q_r     <= '0;
              ovf_r   <= 1'b0;
              cnt_r   <= '0;
              state_r <= D_RUN;
            end
          end
        end
        D_RUN: begin
          dvd_r <= dvd_r << 1;
          if (q_r[63]) ovf_r <= 1'b1;
          q_r   <= {q_r[62:0], ge};
          rem_r <= ge ? 64'(r2 - {1'b0, ud_r}) : r2[63:0];
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(DIV_STEPS - 1)) state_r <= D_FIN;
        end
        D_FIN: begin
          if (neg_r) begin
            if (ovf_r || q_r > 64'h8000_0000_0000_0000) res_r <= S64_MIN;
            else res_r <= $signed(64'd0 - q_r);
          end else begin
            if (ovf_r || q_r[63]) res_r <= S64_MAX;
            else res_r <= $signed(q_r);
          end
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

@@ dv/angle_kalman_filter_2state_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_kalman_filter_2state_top_tb: self-checking bench for the angle filter
// drives update and load words with random gaps, predicts every result with a
// bit-exact fixed-point model of the filter and compares each output word
// ----------------------------------------------------------------------------
module angle_kalman_filter_2state_top_tb;
  import akf_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  angle_kalman_filter_2state_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // filter state as tracked by the bench
  logic [47:0]        q_angle, q_bias, r_meas;
  logic signed [31:0] est_angle, est_bias, est_rate;
  logic signed [63:0] p_aa, p_ab, p_ba, p_bb;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int        n_sent, n_got, n_mismatch, n_load, n_update, idle_cycles;
  bit        timed_out;

  // exact product, floor shift, saturated to 64 bits
  function automatic logic signed [63:0] mulq(input logic signed [63:0] a,
                                              input logic signed [63:0] b,
                                              input int sh);
    logic signed [127:0] p;
    p = (128'(a) * 128'(b)) >>> sh;
    if (p > 128'(S64_MAX)) return S64_MAX;
    if (p < 128'(S64_MIN)) return S64_MIN;
    return p[63:0];
  endfunction

  // (n << 48) / d truncated toward zero, saturated, zero for zero divisor
  function automatic logic signed [63:0] gain_div(input logic signed [63:0] n,
                                                  input logic signed [63:0] d);
    logic signed [127:0] q;
    if (d == 0) return 64'sd0;
    q = (128'(n) <<< 48) / 128'(d);
    if (q > 128'(S64_MAX)) return S64_MAX;
    if (q < 128'(S64_MIN)) return S64_MIN;
    return q[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return S32_MAX;
    if (v < -64'sd2147483648) return S32_MIN;
    return v[31:0];
  endfunction

  task automatic filter_step(input in_word_t w);
    logic signed [63:0] dt, dtbb, t, s, k0, k1, y, aa, ab;
    out_word_t r;
    if (w.mode == MODE_LOAD) begin
      est_angle = w.measured_angle;
      n_load++;
    end else begin
      dt = {40'd0, w.time_step};
      est_rate = sat32(64'(w.gyro_rate) - 64'(est_bias));
      est_angle = sat32(64'(est_angle) + mulq(dt, 64'(est_rate), 24));
      dtbb = mulq(dt, p_bb, 24);
      t = ssub64(dtbb, p_ab);
      t = ssub64(t, p_ba);
      t = sadd64(t, {16'd0, q_angle});
      p_aa = sadd64(p_aa, mulq(dt, t, 24));
      p_ab = ssub64(p_ab, dtbb);
      p_ba = ssub64(p_ba, dtbb);
      p_bb = sadd64(p_bb, mulq({16'd0, q_bias}, dt, 24));
      s = sadd64(p_aa, {16'd0, r_meas});
      k0 = gain_div(p_aa, s);
      k1 = gain_div(p_ba, s);
      y = 64'(w.measured_angle) - 64'(est_angle);
      est_angle = sat32(sadd64(64'(est_angle), mulq(k0, y, 48)));
      est_bias = sat32(sadd64(64'(est_bias), mulq(k1, y, 48)));
      aa = p_aa;
      ab = p_ab;
      p_aa = ssub64(p_aa, mulq(k0, aa, 48));
      p_ab = ssub64(p_ab, mulq(k0, ab, 48));
      p_ba = ssub64(p_ba, mulq(k1, aa, 48));
      p_bb = ssub64(p_bb, mulq(k1, ab, 48));
      n_update++;
    end
    r.filtered_angle = est_angle;
    r.unbiased_rate = est_rate;
    expected_words.push_back(r);
  endtask

  function automatic int pick_gap();
    int c;
    c = $urandom_range(0, 99);
    if (c < 50) return 0;
    if (c < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // handshake as seen at the last rising edge
  logic in_stall_q, in_fire;
  int   recv_gap;

  // driver: word changes only after acceptance
  int send_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_q) begin
        void'(pending_words.pop_front());
        send_gap = pick_gap();
      end
      if (!(in_valid && !in_stall_q) && in_valid) begin
        // still waiting on stall, keep word
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_words[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_stall_q <= in_stall;
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) begin
      filter_step(in_data);
      n_sent++;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_got++;
      if (expected_words.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected word %h", out_data);
      end else if (out_data != expected_words[0]) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("mismatch word %0d: exp angle %h rate %h, got angle %h rate %h",
                   n_got, expected_words[0].filtered_angle,
                   expected_words[0].unbiased_rate, out_data.filtered_angle,
                   out_data.unbiased_rate);
        void'(expected_words.pop_front());
      end else begin
        void'(expected_words.pop_front());
      end
    end
    if (rst_n && !in_fire && !(out_valid && !out_stall)) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= WATCHDOG_CYCLES && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired, %0d words still expected", expected_words.size());
      $display("FAIL angle_kalman_filter_2state_top");
      $finish;
    end
  end

  // receiver stall, random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap = 0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else begin
      recv_gap = pick_gap();
      out_stall <= (recv_gap > 0);
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [47:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= {16'd0, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_ANGLE_NOISE:   q_angle = val;
      REG_BIAS_NOISE:    q_bias = val;
      REG_MEASURE_NOISE: r_meas = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || expected_words.size() > 0 || in_valid)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  function automatic in_word_t rand_word(input int load_pct);
    in_word_t w;
    int c;
    w.mode = ($urandom_range(0, 99) < load_pct) ? MODE_LOAD : MODE_UPDATE;
    c = $urandom_range(0, 9);
    w.measured_angle = (c == 0) ? $urandom() : $signed(32'($urandom_range(0, 23592960)))
                                                  - 32'sd11796480;
    c = $urandom_range(0, 9);
    w.gyro_rate = (c == 0) ? $urandom() : $signed(32'($urandom_range(0, 6553600)))
                                             - 32'sd3276800;
    c = $urandom_range(0, 9);
    w.time_step = (c == 0) ? 24'($urandom()) : 24'($urandom_range(8000, 50000));
    return w;
  endfunction

  function automatic in_word_t mk(input logic m, input logic [31:0] a,
                                  input logic [31:0] g, input logic [23:0] t);
    in_word_t w;
    w.mode = m;
    w.measured_angle = a;
    w.gyro_rate = g;
    w.time_step = t;
    return w;
  endfunction

  logic [47:0] q_set[4], b_set[4], r_set[4];
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_gap = 0;
    q_angle = ANGLE_NOISE_RST;
    q_bias = BIAS_NOISE_RST;
    r_meas = MEASURE_NOISE_RST;
    est_angle = 0; est_bias = 0; est_rate = 0;
    p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset defaults, zero step, extremes, loads, saturation
    pending_words.push_back(mk(MODE_UPDATE, 32'd0, 32'd0, 24'd0));
    pending_words.push_back(mk(MODE_UPDATE, 32'h0001_0000, 32'h0000_8000, 24'd16777));
    pending_words.push_back(mk(MODE_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF));
    pending_words.push_back(mk(MODE_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFFFFF));
    pending_words.push_back(mk(MODE_UPDATE, 32'h8000_0000, 32'h8000_0000, 24'hFFFFFF));
    pending_words.push_back(mk(MODE_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 24'd0));
    pending_words.push_back(mk(MODE_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFFFFFF));
    pending_words.push_back(mk(MODE_LOAD, 32'hFFFF_FFFF, 32'd0, 24'd1));
    pending_words.push_back(mk(MODE_UPDATE, 32'hAAAA_5555, 32'h5555_AAAA, 24'hA5A5A5));
    pending_words.push_back(mk(MODE_UPDATE, 32'h5555_AAAA, 32'hAAAA_5555, 24'h5A5A5A));
    pending_words.push_back(mk(MODE_UPDATE, 32'd0, 32'd0, 24'd1));
    wait_drained();

    // noise corners: zero (measurement noise one), all ones, minimum and moderate, then defaults
    q_set = '{48'd0, 48'hFFFF_FFFF_FFFF, 48'd1, 48'd281474976};
    b_set = '{48'd0, 48'hFFFF_FFFF_FFFF, 48'd1, 48'd2814749};
    r_set = '{48'd1, 48'hFFFF_FFFF_FFFF, 48'd1, 48'd28147497671};
    for (int ph = 0; ph < 5; ph++) begin
      int nwords;
      if (ph < 4) begin
        reg_write(REG_ANGLE_NOISE, q_set[ph]);
        reg_write(REG_BIAS_NOISE, b_set[ph]);
        reg_write(REG_MEASURE_NOISE, r_set[ph]);
      end else begin
        reg_write(REG_ANGLE_NOISE, ANGLE_NOISE_RST);
        reg_write(REG_BIAS_NOISE, BIAS_NOISE_RST);
        reg_write(REG_MEASURE_NOISE, MEASURE_NOISE_RST);
      end
      nwords = (ph == 4) ? 700 : 200;
      for (int i = 0; i < nwords; i++) pending_words.push_back(rand_word(10));
      wait_drained();
    end

    $display("covered %0d update and %0d load words over five noise settings",
             n_update, n_load);
    if (n_mismatch == 0 && expected_words.size() == 0 && !timed_out)
      $display("PASS angle_kalman_filter_2state_top");
    else
      $display("FAIL angle_kalman_filter_2state_top");
    $finish;
  end

endmodule
